// File: src/bte_pkg.sv
package bte_pkg;

  // Fraction bits of the normalized time t (t = 1.0 is 1 << T_BITS).
  localparam int T_BITS = 22;

  // Internal widths: control points (60x scaled), differences, second
  // differences, derivative values before the final divide, and products.
  localparam int PW  = 40;
  localparam int DW  = 41;
  localparam int SW  = 42;
  localparam int VW  = 48;
  localparam int PRW = 64;

  typedef logic signed [PW-1:0]  bte_pt_t;
  typedef logic signed [DW-1:0]  bte_dif_t;
  typedef logic signed [SW-1:0]  bte_sd_t;
  typedef logic signed [VW-1:0]  bte_val_t;
  typedef logic signed [PRW-1:0] bte_prd_t;
  typedef logic [T_BITS:0]       bte_t_t;

  localparam bte_t_t   T_ONE  = bte_t_t'(1) << T_BITS;
  localparam bte_prd_t T_HALF = bte_prd_t'(1) <<< (T_BITS - 1);

  // Limits on |v| + 30 beyond which the divide by 60 saturates.
  localparam logic [48:0] SAT_POS_LIM = 49'd128849018880;
  localparam logic [48:0] SAT_NEG_LIM = 49'd128849018940;
  localparam logic [31:0] S32_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN     = 32'h8000_0000;
  localparam logic [6:0]  DIVISOR     = 7'd60;

  // One item as it moves through the curve pipeline.
  typedef struct packed {
    logic             mode;
    bte_t_t           t;
    bte_pt_t [5:0]    p;
    bte_dif_t         fd;
    bte_sd_t          sd;
    bte_val_t         acc;
  } bte_item_t;

  typedef struct packed {
    logic [7:0] q;
    logic [5:0] r;
  } bte_d60_t;

  // Eight steps of long division by 60: remainder in, eight dividend bits in.
  function automatic bte_d60_t bte_div60_byte(input logic [5:0] r_in, input logic [7:0] b);
    logic [6:0] r;
    bte_d60_t   res;
    r = {1'b0, r_in};
    res = '0;
    for (int k = 7; k >= 0; k--) begin
      r = {r[5:0], b[k]};
      if (r >= DIVISOR) begin
        res.q[k] = 1'b1;
        r = r - DIVISOR;
      end
    end
    res.r = r[5:0];
    return res;
  endfunction

endpackage

// File: src/bte_tdiv.sv
module bte_tdiv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [31:0]         tn,
  input  logic [31:0]         te,
  input  bte_pkg::bte_item_t  in_item,
  output logic                out_vld,
  output bte_pkg::bte_item_t  out_item
);

  localparam int NST = bte_pkg::T_BITS;

  logic [NST-1:0]        vld_r;
  logic [31:0]           rem_r  [NST];
  logic [31:0]           rem_nxt[NST];
  logic [31:0]           te_r   [NST];
  logic [NST-1:0]        q_r    [NST];
  logic [NST-1:0]        q_nxt  [NST];
  logic                  one_r  [NST];
  bte_pkg::bte_item_t    item_r [NST];
  logic                  one_in;

  // Zero duration or time at or past the end both pin t to one.
  assign one_in = (te == 32'd0) || (tn >= te);

  // One restoring quotient bit per stage.
  always_comb begin
    logic [31:0]    srem;
    logic [31:0]    ste;
    logic [NST-1:0] sq;
    logic [32:0]    r2;
    logic           ge;
    for (int k = 0; k < NST; k++) begin
      if (k == 0) begin
        srem = one_in ? 32'd0 : tn;
        ste  = te;
        sq   = '0;
      end else begin
        srem = rem_r[k-1];
        ste  = te_r[k-1];
        sq   = q_r[k-1];
      end
      r2 = {srem, 1'b0};
      ge = (r2 >= {1'b0, ste});
      rem_nxt[k] = ge ? 32'(r2 - {1'b0, ste}) : r2[31:0];
      q_nxt[k]   = {sq[NST-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
      te_r[0]   <= te;
      one_r[0]  <= one_in;
      item_r[0] <= in_item;
      for (int k = 1; k < NST; k++) begin
        te_r[k]   <= te_r[k-1];
        one_r[k]  <= one_r[k-1];
        item_r[k] <= item_r[k-1];
      end
    end
  end

  // Attach the finished t to the item.
  always_comb begin
    out_item   = item_r[NST-1];
    out_item.t = one_r[NST-1] ? bte_pkg::T_ONE : {1'b0, q_r[NST-1]};
  end

  assign out_vld = vld_r[NST-1];

endmodule

// File: src/bte_lvl.sv
module bte_lvl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic                byp,
  input  bte_pkg::bte_item_t  in_item,
  output logic                out_vld,
  output bte_pkg::bte_item_t  out_item
);

  logic                 a_vld_r, b_vld_r, c_vld_r;
  logic                 a_byp_r, b_byp_r;
  bte_pkg::bte_item_t   a_item_r, a_item_nxt, b_item_r, c_item_r, c_item_nxt;
  bte_pkg::bte_dif_t    a_d_r  [5];
  bte_pkg::bte_dif_t    a_d_nxt[5];
  bte_pkg::bte_prd_t    b_prod_r  [5];
  bte_pkg::bte_prd_t    b_prod_nxt[5];

  // Stage a: neighbor differences, plus first and second difference of the
  // leading points for the derivative outputs.
  always_comb begin
    a_item_nxt = in_item;
    for (int i = 0; i < 5; i++) begin
      a_d_nxt[i] = bte_pkg::bte_dif_t'($signed(in_item.p[i+1]))
                 - bte_pkg::bte_dif_t'($signed(in_item.p[i]));
    end
    a_item_nxt.fd = a_d_nxt[0];
    a_item_nxt.sd = bte_pkg::bte_sd_t'($signed(in_item.p[0]))
                  - (bte_pkg::bte_sd_t'($signed(in_item.p[1])) <<< 1)
                  + bte_pkg::bte_sd_t'($signed(in_item.p[2]));
  end

  // Stage b: scale each difference by t.
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      b_prod_nxt[i] = a_d_r[i] * $signed({1'b0, a_item_r.t});
    end
  end

  // Stage c: unless bypassed, round to nearest and add back onto the left point.
  always_comb begin
    c_item_nxt = b_item_r;
    if (!b_byp_r) begin
      for (int i = 0; i < 5; i++) begin
        c_item_nxt.p[i] = $signed(b_item_r.p[i])
          + bte_pkg::bte_pt_t'((b_prod_r[i] + bte_pkg::T_HALF) >>> bte_pkg::T_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item_r <= a_item_nxt;
      a_byp_r  <= byp;
      b_item_r <= a_item_r;
      b_byp_r  <= a_byp_r;
      c_item_r <= c_item_nxt;
      for (int i = 0; i < 5; i++) begin
        a_d_r[i]    <= a_d_nxt[i];
        b_prod_r[i] <= b_prod_nxt[i];
      end
    end
  end

  assign out_vld  = c_vld_r;
  assign out_item = c_item_r;

endmodule

// File: src/bte_fin.sv
module bte_fin (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_vld,
  input  logic [2:0][bte_pkg::VW-1:0]    in_val,
  output logic                           out_vld,
  output logic [2:0][31:0]               out_val
);

  localparam int NDV = 5;

  logic                f0_vld_r;
  logic [NDV-1:0]      dv_vld_r;
  logic                o_vld_r;
  logic                f0_neg_r[3], f0_sat_r[3];
  logic [39:0]         f0_dvd_r[3];
  logic                f0_neg_nxt[3], f0_sat_nxt[3];
  logic [39:0]         f0_dvd_nxt[3];
  logic                dv_neg_r[NDV][3], dv_sat_r[NDV][3];
  logic [39:0]         dv_dd_r [NDV][3];
  logic [39:0]         dv_q_r  [NDV][3];
  logic [39:0]         dv_q_nxt[NDV][3];
  logic [5:0]          dv_rm_r  [NDV][3];
  logic [5:0]          dv_rm_nxt[NDV][3];
  logic [2:0][31:0]    o_val_r, o_val_nxt;

  // Magnitude plus half the divisor, and the saturation decision.
  always_comb begin
    logic [47:0] mag;
    logic [48:0] m;
    for (int j = 0; j < 3; j++) begin
      f0_neg_nxt[j] = in_val[j][bte_pkg::VW-1];
      mag           = f0_neg_nxt[j] ? 48'(-in_val[j]) : 48'(in_val[j]);
      m             = {1'b0, mag} + 49'd30;
      f0_sat_nxt[j] = f0_neg_nxt[j] ? (m >= bte_pkg::SAT_NEG_LIM)
                                    : (m >= bte_pkg::SAT_POS_LIM);
      f0_dvd_nxt[j] = m[39:0];
    end
  end

  // Long division by 60, one dividend byte per stage, MSB first.
  always_comb begin
    logic [5:0]        rin;
    logic [39:0]       qin;
    logic [39:0]       dd;
    bte_pkg::bte_d60_t res;
    for (int s = 0; s < NDV; s++) begin
      for (int j = 0; j < 3; j++) begin
        if (s == 0) begin
          rin = '0;
          qin = '0;
          dd  = f0_dvd_r[j];
        end else begin
          rin = dv_rm_r[s-1][j];
          qin = dv_q_r[s-1][j];
          dd  = dv_dd_r[s-1][j];
        end
        res = bte_pkg::bte_div60_byte(rin, dd[39-8*s -: 8]);
        dv_q_nxt[s][j]  = {qin[31:0], res.q};
        dv_rm_nxt[s][j] = res.r;
      end
    end
  end

  // Sign and clamp.
  always_comb begin
    logic [31:0] q32;
    for (int j = 0; j < 3; j++) begin
      q32 = dv_q_r[NDV-1][j][31:0];
      if (dv_sat_r[NDV-1][j]) begin
        o_val_nxt[j] = dv_neg_r[NDV-1][j] ? bte_pkg::S32_MIN : bte_pkg::S32_MAX;
      end else begin
        o_val_nxt[j] = dv_neg_r[NDV-1][j] ? 32'(-q32) : q32;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_vld_r <= 1'b0;
      dv_vld_r <= '0;
      o_vld_r  <= 1'b0;
    end else if (adv) begin
      f0_vld_r <= in_vld;
      dv_vld_r <= {dv_vld_r[NDV-2:0], f0_vld_r};
      o_vld_r  <= dv_vld_r[NDV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        f0_neg_r[j] <= f0_neg_nxt[j];
        f0_sat_r[j] <= f0_sat_nxt[j];
        f0_dvd_r[j] <= f0_dvd_nxt[j];
        for (int s = 0; s < NDV; s++) begin
          dv_q_r[s][j]  <= dv_q_nxt[s][j];
          dv_rm_r[s][j] <= dv_rm_nxt[s][j];
          if (s == 0) begin
            dv_neg_r[s][j] <= f0_neg_r[j];
            dv_sat_r[s][j] <= f0_sat_r[j];
            dv_dd_r[s][j]  <= f0_dvd_r[j];
          end else begin
            dv_neg_r[s][j] <= dv_neg_r[s-1][j];
            dv_sat_r[s][j] <= dv_sat_r[s-1][j];
            dv_dd_r[s][j]  <= dv_dd_r[s-1][j];
          end
        end
      end
      o_val_r <= o_val_nxt;
    end
  end

  assign out_vld = o_vld_r;
  assign out_val = o_val_r;

endmodule

// File: src/bezier_trajectory_eval.sv
// Throughput: one word per cycle while the output is not stalled; the 22-stage time
// divider, five three-stage lerp levels, one derivative stage and a seven-stage
// divide-by-60 all advance together.
// The whole pipeline holds while a result waits at the output register.
// Reset (rst_n low at a clock edge) empties the pipeline and selects quintic mode.
module bezier_trajectory_eval (
  input  logic         clk,
  input  logic         rst_n,
  // time_now, time_end, pos_start, vel_start, acc_start, pos_end, vel_end, acc_end
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,
  // pos_ref, vel_ref, acc_ref
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data
);

  logic                         adv;
  logic                         mode_r;
  bte_pkg::bte_item_t           ent_item;
  logic                         tdv_vld;
  bte_pkg::bte_item_t           tdv_item;
  logic                         lv_vld [5];
  bte_pkg::bte_item_t           lv_in  [5];
  bte_pkg::bte_item_t           lv_out [5];
  logic                         lv_byp [5];
  logic                         e_vld_r;
  logic                         e_mode_r;
  bte_pkg::bte_val_t            e_pos_r, e_vel_r, e_acc_r;
  logic [2:0][bte_pkg::VW-1:0]  fin_in;
  logic [2:0][31:0]             fin_out;

  // The pipeline moves whenever the output register is free or being read.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  // Degree register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  // Control points scaled by 60, built from the boundary conditions.
  always_comb begin
    bte_pkg::bte_pt_t x0, v0, a0, x1, v1, a1;
    x0 = bte_pkg::bte_pt_t'($signed(in_tdata[95:64]));
    v0 = bte_pkg::bte_pt_t'($signed(in_tdata[127:96]));
    a0 = bte_pkg::bte_pt_t'($signed(in_tdata[159:128]));
    x1 = bte_pkg::bte_pt_t'($signed(in_tdata[191:160]));
    v1 = bte_pkg::bte_pt_t'($signed(in_tdata[223:192]));
    a1 = bte_pkg::bte_pt_t'($signed(in_tdata[255:224]));
    ent_item      = '0;
    ent_item.mode = mode_r;
    ent_item.p[0] = x0 * 60;
    if (mode_r) begin
      ent_item.p[1] = x0 * 60 + v0 * 12;
      ent_item.p[2] = x0 * 60 + v0 * 24 + a0 * 3;
      ent_item.p[3] = x1 * 60 - v1 * 24 + a1 * 3;
      ent_item.p[4] = x1 * 60 - v1 * 12;
      ent_item.p[5] = x1 * 60;
    end else begin
      ent_item.p[1] = x0 * 60 + v0 * 20;
      ent_item.p[2] = x1 * 60 - v1 * 20;
      ent_item.p[3] = x1 * 60;
    end
  end

  bte_tdiv u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_tvalid),
    .tn       (in_tdata[31:0]),
    .te       (in_tdata[63:32]),
    .in_item  (ent_item),
    .out_vld  (tdv_vld),
    .out_item (tdv_item)
  );

  // Level inputs; cubic items skip the first two levels, and the
  // acceleration is taken from the second difference after level three.
  always_comb begin
    lv_in[0] = tdv_item;
    for (int l = 1; l < 5; l++) begin
      lv_in[l] = lv_out[l-1];
    end
    lv_in[4].acc = lv_out[3].mode ? bte_pkg::bte_val_t'(lv_out[3].sd) * 20 : '0;
    lv_byp[0] = !tdv_item.mode;
    lv_byp[1] = !lv_out[0].mode;
    lv_byp[2] = 1'b0;
    lv_byp[3] = 1'b0;
    lv_byp[4] = 1'b0;
  end

  for (genvar l = 0; l < 5; l++) begin : g_lvl
    bte_lvl u_lvl (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   ((l == 0) ? tdv_vld : lv_vld[(l == 0) ? 0 : l-1]),
      .byp      (lv_byp[l]),
      .in_item  (lv_in[l]),
      .out_vld  (lv_vld[l]),
      .out_item (lv_out[l])
    );
  end

  // Derivative stage: position, n times the last difference, acceleration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= lv_vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_mode_r <= lv_out[4].mode;
      e_pos_r  <= bte_pkg::bte_val_t'($signed(lv_out[4].p[0]));
      e_vel_r  <= bte_pkg::bte_val_t'(lv_out[4].fd) * (lv_out[4].mode ? 5 : 3);
      e_acc_r  <= lv_out[4].acc;
    end
  end

  assign fin_in[0] = e_pos_r;
  assign fin_in[1] = e_vel_r;
  assign fin_in[2] = e_acc_r;

  bte_fin u_fin (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (e_vld_r),
    .in_val  (fin_in),
    .out_vld (out_tvalid),
    .out_val (fin_out)
  );

  assign out_tdata = {fin_out[2], fin_out[1], fin_out[0]};

  // A stalled pipeline keeps every stage's occupancy.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({tdv_vld, lv_vld[0], lv_vld[4], e_vld_r, out_tvalid}))
    else $error("pipeline occupancy changed during a stall");

  // Normalized time never exceeds one.
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    tdv_vld |-> (tdv_item.t <= bte_pkg::T_ONE))
    else $error("normalized time above one");

  // Cubic items carry no acceleration.
  a_cubic_acc: assert property (@(posedge clk) disable iff (!rst_n)
    e_vld_r && !e_mode_r |-> (e_acc_r == '0))
    else $error("cubic item with nonzero acceleration");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
